[hw/rtl/mpq_pkg.sv]
// Package for the multilevel priority queue: sizes, field widths, command and
// status codes, shared structs and the address helper.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package mpq_pkg;

    // Storage geometry.
    localparam int MAX_LEVELS  = 8;
    localparam int LEVEL_DEPTH = 16;
    localparam int ID_WIDTH    = 16;

    localparam int LVL_W   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int ACT_W   = $clog2(MAX_LEVELS + 1);
    localparam int PTR_W   = $clog2(LEVEL_DEPTH);
    localparam int FILL_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int TOTAL_W = $clog2(MAX_LEVELS * LEVEL_DEPTH + 1);
    localparam int MEM_DEPTH = MAX_LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W  = $clog2(MEM_DEPTH);

    // Fixed field widths of the ports.
    localparam int CFG_W    = 4;
    localparam int CMD_W    = 2;
    localparam int TASK_W   = 16;
    localparam int PRIO_W   = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 8;
    localparam int LCOUNT_W = 5;

    localparam logic [CFG_W-1:0] LEVELS_RESET = CFG_W'(8);

    // Commands; the unused code behaves as a query.
    localparam logic [CMD_W-1:0] CMD_ENQ   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD_PRIO = 2'd3;

    // Update request from the sequencer to the level bookkeeping.
    typedef struct packed {
        logic enq;
        logic deq;
    } lvl_op_t;

    // Highest non-empty active level.
    typedef struct packed {
        logic             found;
        logic [LVL_W-1:0] lvl;
    } top_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TASK_W-1:0]   head_task_id;
        logic [PRIO_W-1:0]   head_priority;
        logic [COUNT_W-1:0]  total_count;
        logic [LCOUNT_W-1:0] level_count;
    } out_item_t;

    // Flat store address of slot ptr in level lvl.
    function automatic logic [ADDR_W-1:0] mpq_addr(input logic [LVL_W-1:0] lvl,
                                                   input logic [PTR_W-1:0] ptr);
        return ADDR_W'(32'(lvl) * LEVEL_DEPTH + 32'(ptr));
    endfunction

endpackage

[hw/rtl/mpq_if.sv]
// Handshake interfaces for the command and result channels of the queue.
// Depends on mpq_pkg for the field widths.
`timescale 1ns / 1ps

interface mpq_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [mpq_pkg::CMD_W-1:0]    cmd;
    logic [mpq_pkg::TASK_W-1:0]   task_id;
    logic [mpq_pkg::PRIO_W-1:0]   priority_req;

    modport source (output valid, output cmd, output task_id, output priority_req,
                    input ready);
    modport sink   (input valid, input cmd, input task_id, input priority_req,
                    output ready);
endinterface

interface mpq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [mpq_pkg::STATUS_W-1:0]  status;
    logic [mpq_pkg::TASK_W-1:0]    head_task_id;
    logic [mpq_pkg::PRIO_W-1:0]    head_priority;
    logic [mpq_pkg::COUNT_W-1:0]   total_count;
    logic [mpq_pkg::LCOUNT_W-1:0]  level_count;

    modport source (output valid, output status, output head_task_id,
                    output head_priority, output total_count, output level_count,
                    input ready);
    modport sink   (input valid, input status, input head_task_id,
                    input head_priority, input total_count, input level_count,
                    output ready);
endinterface

[hw/rtl/mpq_store.sv]
// Task store: one memory holding every level's ring of task identifiers.
// Depends on mpq_pkg for depth and widths.
`timescale 1ns / 1ps

module mpq_store (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [mpq_pkg::ADDR_W-1:0]    wr_addr,
    input  logic [mpq_pkg::ID_WIDTH-1:0]  wr_data,
    input  logic                          rd_en,
    input  logic [mpq_pkg::ADDR_W-1:0]    rd_addr,
    output logic [mpq_pkg::ID_WIDTH-1:0]  rd_data
);

    logic [mpq_pkg::ID_WIDTH-1:0] mem [mpq_pkg::MEM_DEPTH];
    logic [mpq_pkg::ID_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // The read word is held until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/mpq_levels.sv]
// Per-level bookkeeping: head and tail pointers, fill counts, the total count,
// and the search for the highest non-empty active level. Depends on mpq_pkg.
`timescale 1ns / 1ps

module mpq_levels (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mpq_pkg::ACT_W-1:0]     active,
    input  logic [mpq_pkg::LVL_W-1:0]     sel_lvl,
    input  mpq_pkg::lvl_op_t              op,
    output logic [mpq_pkg::PTR_W-1:0]     sel_head,
    output logic [mpq_pkg::PTR_W-1:0]     sel_tail,
    output logic [mpq_pkg::FILL_W-1:0]    sel_fill,
    output logic [mpq_pkg::TOTAL_W-1:0]   total,
    output mpq_pkg::top_t                 top
);

    logic [mpq_pkg::PTR_W-1:0]   head_reg  [mpq_pkg::MAX_LEVELS];
    logic [mpq_pkg::PTR_W-1:0]   tail_reg  [mpq_pkg::MAX_LEVELS];
    logic [mpq_pkg::FILL_W-1:0]  fill_reg  [mpq_pkg::MAX_LEVELS];
    logic [mpq_pkg::TOTAL_W-1:0] total_reg;
    logic [mpq_pkg::PTR_W-1:0]   head_next;
    logic [mpq_pkg::PTR_W-1:0]   tail_next;

    function automatic logic [mpq_pkg::PTR_W-1:0] wrap_inc(
        input logic [mpq_pkg::PTR_W-1:0] p);
        return (p == mpq_pkg::PTR_W'(mpq_pkg::LEVEL_DEPTH - 1)) ?
               '0 : p + mpq_pkg::PTR_W'(1);
    endfunction

    assign sel_head  = head_reg[sel_lvl];
    assign sel_tail  = tail_reg[sel_lvl];
    assign sel_fill  = fill_reg[sel_lvl];
    assign total     = total_reg;
    assign head_next = wrap_inc(sel_head);
    assign tail_next = wrap_inc(sel_tail);

    // Later (higher) levels override earlier ones.
    always_comb
    begin
        top = '0;
        for (int i = 0; i < mpq_pkg::MAX_LEVELS; i++)
        begin
            if ((32'(i) < 32'(active)) && (fill_reg[i] != '0))
            begin
                top.found = 1'b1;
                top.lvl   = mpq_pkg::LVL_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mpq_pkg::MAX_LEVELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
            total_reg <= '0;
        end
        else if (op.enq)
        begin
            tail_reg[sel_lvl] <= tail_next;
            fill_reg[sel_lvl] <= sel_fill + mpq_pkg::FILL_W'(1);
            total_reg         <= total_reg + mpq_pkg::TOTAL_W'(1);
        end
        else if (op.deq)
        begin
            head_reg[sel_lvl] <= head_next;
            fill_reg[sel_lvl] <= sel_fill - mpq_pkg::FILL_W'(1);
            total_reg         <= total_reg - mpq_pkg::TOTAL_W'(1);
        end
    end

endmodule

[hw/rtl/multilevel_priority_queue_core.sv]
// Multilevel priority queue core. An enqueue or query passes the states
// EXEC, READ and RESP before its result is registered, a dequeue only EXEC
// and RESP; a new command is taken only in IDLE, after the last result is
// registered. READ holds the task store read of the new head, which for an
// enqueue or query must follow the write and the pointer update. A result
// that waits on the output holds the sequencer until the beat is taken.
// rst_n clears all pointers and counts and sets eight levels in use; the
// task store itself is not cleared.
`timescale 1ns / 1ps

module multilevel_priority_queue_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mpq_pkg::CFG_W-1:0]     cfg_data,
    mpq_cmd_if.sink                       in_ch,
    mpq_rsp_if.source                     out_ch
);

    // Sequencer states. A command walks through EXEC (update and, for a
    // dequeue, the store read), READ (store read of the new head for the
    // other commands) and RESP (result into the output register).
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_RESP = 2'd3;

    logic [1:0]                     state_reg, state_next;
    logic [mpq_pkg::CFG_W-1:0]      levels_reg;
    logic [mpq_pkg::CMD_W-1:0]      cmd_reg;
    logic [mpq_pkg::ID_WIDTH-1:0]   tid_reg;
    logic [mpq_pkg::PRIO_W-1:0]     prio_reg;
    logic [mpq_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [mpq_pkg::PRIO_W-1:0]     head_pr_reg, head_pr_next;
    logic                           out_valid_reg;
    mpq_pkg::out_item_t             out_data_reg;

    logic [mpq_pkg::ACT_W-1:0]      active;
    logic                           prio_ok;
    logic [mpq_pkg::LVL_W-1:0]      prio_lvl;
    logic [mpq_pkg::LVL_W-1:0]      sel_lvl;
    logic                           out_free;

    mpq_pkg::lvl_op_t               op;
    mpq_pkg::top_t                  top;
    logic [mpq_pkg::PTR_W-1:0]      sel_head;
    logic [mpq_pkg::PTR_W-1:0]      sel_tail;
    logic [mpq_pkg::FILL_W-1:0]     sel_fill;
    logic [mpq_pkg::TOTAL_W-1:0]    total;

    logic                           wr_en;
    logic                           rd_en;
    logic [mpq_pkg::ADDR_W-1:0]     rd_addr;
    logic [mpq_pkg::ID_WIDTH-1:0]   rd_data;

    // A level count of zero acts as one, and anything past the number of
    // levels built acts as that number.
    always_comb
    begin
        if (levels_reg == '0)
        begin
            active = mpq_pkg::ACT_W'(1);
        end
        else if (32'(levels_reg) > mpq_pkg::MAX_LEVELS)
        begin
            active = mpq_pkg::ACT_W'(mpq_pkg::MAX_LEVELS);
        end
        else
        begin
            active = mpq_pkg::ACT_W'(levels_reg);
        end
    end

    assign prio_ok  = (prio_reg != '0) && (32'(prio_reg) <= 32'(active));
    assign prio_lvl = mpq_pkg::LVL_W'(prio_reg - mpq_pkg::PRIO_W'(1));

    // The bookkeeping is looked at through one level at a time: the named
    // level for enqueue, query and the reported fill, the top level for the
    // dequeue and for the head read.
    assign sel_lvl = ((state_reg == ST_RESP) ||
                      ((state_reg == ST_EXEC) && (cmd_reg != mpq_pkg::CMD_DEQ))) ?
                     prio_lvl : top.lvl;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        status_next  = status_reg;
        head_pr_next = head_pr_reg;
        op           = '0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = mpq_pkg::mpq_addr(top.lvl, sel_head);
        unique case (state_reg)
            ST_IDLE:
            begin
                status_next  = mpq_pkg::STAT_OK;
                head_pr_next = '0;
                if (in_ch.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd_reg == mpq_pkg::CMD_DEQ)
                begin
                    // An empty dequeue reports no head; the read is skipped.
                    if (top.found)
                    begin
                        rd_en        = 1'b1;
                        op.deq       = 1'b1;
                        head_pr_next = mpq_pkg::PRIO_W'(32'(top.lvl) + 1);
                    end
                    else
                    begin
                        status_next = mpq_pkg::STAT_EMPTY;
                    end
                    state_next = ST_RESP;
                end
                else
                begin
                    if (!prio_ok)
                    begin
                        status_next = mpq_pkg::STAT_BAD_PRIO;
                    end
                    else if (cmd_reg == mpq_pkg::CMD_ENQ)
                    begin
                        if (32'(sel_fill) >= mpq_pkg::LEVEL_DEPTH)
                        begin
                            status_next = mpq_pkg::STAT_FULL;
                        end
                        else
                        begin
                            wr_en  = 1'b1;
                            op.enq = 1'b1;
                        end
                    end
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                // Front of the highest non-empty level after the update.
                if (top.found)
                begin
                    rd_en        = 1'b1;
                    head_pr_next = mpq_pkg::PRIO_W'(32'(top.lvl) + 1);
                end
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            levels_reg    <= mpq_pkg::LEVELS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                levels_reg <= cfg_data;
            end
            if ((state_reg == ST_RESP) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Command fields and working values; no reset needed.
    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        head_pr_reg <= head_pr_next;
        if (in_ch.valid && in_ch.ready)
        begin
            cmd_reg  <= in_ch.cmd;
            tid_reg  <= mpq_pkg::ID_WIDTH'(in_ch.task_id);
            prio_reg <= in_ch.priority_req;
        end
        if ((state_reg == ST_RESP) && out_free)
        begin
            out_data_reg.status        <= status_reg;
            out_data_reg.head_task_id  <= (head_pr_reg != '0) ?
                                          mpq_pkg::TASK_W'(rd_data) : '0;
            out_data_reg.head_priority <= head_pr_reg;
            out_data_reg.total_count   <= mpq_pkg::COUNT_W'(total);
            out_data_reg.level_count   <= prio_ok ? mpq_pkg::LCOUNT_W'(sel_fill) : '0;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.status        = out_data_reg.status;
    assign out_ch.head_task_id  = out_data_reg.head_task_id;
    assign out_ch.head_priority = out_data_reg.head_priority;
    assign out_ch.total_count   = out_data_reg.total_count;
    assign out_ch.level_count   = out_data_reg.level_count;

    mpq_levels u_levels (
        .clk      (clk),
        .rst_n    (rst_n),
        .active   (active),
        .sel_lvl  (sel_lvl),
        .op       (op),
        .sel_head (sel_head),
        .sel_tail (sel_tail),
        .sel_fill (sel_fill),
        .total    (total),
        .top      (top)
    );

    mpq_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (mpq_pkg::mpq_addr(prio_lvl, sel_tail)),
        .wr_data (tid_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

[hw/rtl/mpq_checker.sv]
// Port-level checks for the multilevel priority queue core, with the bind
// that attaches them. Depends on mpq_pkg and multilevel_priority_queue_core.
`timescale 1ns / 1ps

module mpq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic [mpq_pkg::STATUS_W-1:0]  status,
    input logic [mpq_pkg::TASK_W-1:0]    head_task_id,
    input logic [mpq_pkg::PRIO_W-1:0]    head_priority,
    input logic [mpq_pkg::LCOUNT_W-1:0]  level_count
);

    // One command at a time: the block is busy right after taking a beat.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("command accepted while the previous one is in progress");

    // With no head reported the identifier must read as zero.
    a_no_head_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (head_priority == '0) |-> (head_task_id == '0))
        else $error("head identifier set without a head level");

    // An empty dequeue reports no head.
    a_empty_no_head: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == mpq_pkg::STAT_EMPTY) |-> (head_priority == '0))
        else $error("empty status with a head level");

    // A bad priority reports no level fill, and no fill passes the depth.
    a_level_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((status != mpq_pkg::STAT_BAD_PRIO) || (level_count == '0)) &&
                      (32'(level_count) <= mpq_pkg::LEVEL_DEPTH))
        else $error("level fill out of range");

endmodule

bind multilevel_priority_queue_core mpq_checker u_mpq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .status        (out_ch.status),
    .head_task_id  (out_ch.head_task_id),
    .head_priority (out_ch.head_priority),
    .level_count   (out_ch.level_count)
);
